>>> sv/deq_pkg.sv
package deq_pkg;

  localparam int WORD_W = 32;

  typedef logic signed [WORD_W-1:0] word_t;

  typedef enum logic [1:0] {
    CMD_PUSH_FRONT = 2'd0,
    CMD_PUSH_REAR  = 2'd1,
    CMD_POP_FRONT  = 2'd2,
    CMD_POP_REAR   = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_OVERFLOW  = 2'd1,
    ST_UNDERFLOW = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    OP_HOLD   = 2'd0,
    OP_SHIFT  = 2'd1,
    OP_LOAD   = 2'd2,
    OP_ROTATE = 2'd3
  } cell_op_t;

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_LIST = 2'b10
  } state_t;

endpackage

>>> sv/deq_cell.sv
module deq_cell #(
  parameter int INDEX = 0,
  parameter int IDX_W = 4
) (
  input  logic                clk,
  input  deq_pkg::cell_op_t   op,
  input  logic [IDX_W-1:0]    sel,
  input  deq_pkg::word_t      left_data,
  input  deq_pkg::word_t      right_data,
  input  deq_pkg::word_t      load_data,
  input  deq_pkg::word_t      wrap_data,
  output deq_pkg::word_t      data
);
  import deq_pkg::*;

  localparam logic [IDX_W-1:0] MY_INDEX = IDX_W'(INDEX);

  always_ff @(posedge clk) begin
    unique case (op)
      OP_HOLD: begin
        data <= data;
      end
      OP_SHIFT: begin
        data <= left_data;
      end
      OP_LOAD: begin
        if (MY_INDEX == sel) begin
          data <= load_data;
        end
      end
      OP_ROTATE: begin
        if (MY_INDEX < sel) begin
          data <= right_data;
        end else if (MY_INDEX == sel) begin
          data <= wrap_data;
        end
      end
      default: begin
        data <= data;
      end
    endcase
  end

endmodule

>>> sv/double_ended_queue.sv
// Channel   Direction  Signals                    Word layout
// s_*       in         tvalid tready tdata tuser  tdata: value; tuser: command
// m_*       out        tvalid tready tdata tuser  tdata: value_res; tuser: status,
//                      tlast                      has_value; tlast: last
// A command is taken in a single handshake and applied to the row of cells at once.
// The listing then sends one word per stored word, or a single word when empty.
// The listing rotates the row of cells, and count rotations restore the order.
// Reset clears the count and the control state; the cells are not cleared.
// A stall on the output holds the listing; the next command is taken once the
// final word of the listing has been loaded into the output register.
module double_ended_queue #(
  parameter int CAPACITY = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // [31:0] value
  input  logic [1:0]  s_tuser,   // [1:0] command
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // [31:0] value_res
  output logic [2:0]  m_tuser,   // [1:0] status, [2] has_value
  output logic        m_tlast
);
  import deq_pkg::*;

  localparam int IDX_W = $clog2(CAPACITY);
  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(CAPACITY);

  state_t           state;
  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] count_next;
  logic [IDX_W-1:0] list_index;
  status_t          status;
  status_t          status_next;
  logic             accept;
  logic             out_load;
  logic             list_last;
  logic             empty;
  logic             full;
  logic [IDX_W-1:0] tail;
  cmd_t             cmd;
  cell_op_t         op;
  logic [IDX_W-1:0] sel;
  word_t            in_word;
  word_t            cell_q [CAPACITY];

  logic             out_valid;
  status_t          out_status;
  logic             out_has_value;
  word_t            out_value;
  logic             out_last;

  assign s_tready  = (state == S_IDLE);
  assign accept    = s_tvalid && s_tready;
  assign cmd       = cmd_t'(s_tuser);
  assign in_word   = word_t'(s_tdata);
  assign empty     = (count == '0);
  assign full      = (count == FULL_COUNT);
  assign tail      = IDX_W'(count - CNT_W'(1));
  assign out_load  = (state == S_LIST) && (!out_valid || m_tready);
  assign list_last = empty || (list_index == tail);

  always_comb begin
    op          = OP_HOLD;
    sel         = '0;
    count_next  = count;
    status_next = ST_OK;
    if (accept) begin
      unique case (cmd)
        CMD_PUSH_FRONT: begin
          if (full) begin
            status_next = ST_OVERFLOW;
          end else begin
            op         = OP_SHIFT;
            count_next = count + CNT_W'(1);
          end
        end
        CMD_PUSH_REAR: begin
          if (full) begin
            status_next = ST_OVERFLOW;
          end else begin
            op         = OP_LOAD;
            sel        = IDX_W'(count);
            count_next = count + CNT_W'(1);
          end
        end
        CMD_POP_FRONT: begin
          if (empty) begin
            status_next = ST_UNDERFLOW;
          end else begin
            op         = OP_ROTATE;
            sel        = tail;
            count_next = count - CNT_W'(1);
          end
        end
        CMD_POP_REAR: begin
          if (empty) begin
            status_next = ST_UNDERFLOW;
          end else begin
            count_next = count - CNT_W'(1);
          end
        end
        default: begin
          status_next = ST_OK;
        end
      endcase
    end else if (out_load && !empty) begin
      op  = OP_ROTATE;
      sel = tail;
    end
  end

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    word_t left_w;
    word_t right_w;
    if (i == 0) begin : g_head
      assign left_w = in_word;
    end else begin : g_body
      assign left_w = cell_q[i-1];
    end
    if (i == CAPACITY - 1) begin : g_end
      assign right_w = '0;
    end else begin : g_inner
      assign right_w = cell_q[i+1];
    end
    deq_cell #(
      .INDEX (i),
      .IDX_W (IDX_W)
    ) u_cell (
      .clk        (clk),
      .op         (op),
      .sel        (sel),
      .left_data  (left_w),
      .right_data (right_w),
      .load_data  (in_word),
      .wrap_data  (cell_q[0]),
      .data       (cell_q[i])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      count      <= '0;
      list_index <= '0;
      status     <= ST_OK;
      out_valid  <= 1'b0;
    end else begin
      count <= count_next;
      if (accept) begin
        status <= status_next;
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            state      <= S_LIST;
            list_index <= '0;
          end
        end
        S_LIST: begin
          if (out_load) begin
            if (list_last) begin
              state      <= S_IDLE;
              list_index <= '0;
            end else begin
              list_index <= list_index + IDX_W'(1);
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_status    <= status;
      out_has_value <= !empty;
      out_value     <= empty ? word_t'(0) : cell_q[0];
      out_last      <= list_last;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = out_value;
  assign m_tuser  = {out_has_value, out_status};
  assign m_tlast  = out_last;

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= FULL_COUNT)
    else $error("entry count above capacity");

  a_accept_lists: assert property (@(posedge clk) disable iff (rst)
    accept |=> (state == S_LIST) && !s_tready)
    else $error("listing did not follow an accepted command");

  a_last_ends: assert property (@(posedge clk) disable iff (rst)
    out_load && list_last |=> (state == S_IDLE) && m_tvalid && m_tlast)
    else $error("final word of a listing did not end it");

  a_underflow_keeps: assert property (@(posedge clk) disable iff (rst)
    accept && empty && (cmd == CMD_POP_FRONT || cmd == CMD_POP_REAR)
      |=> (count == '0) && (status == ST_UNDERFLOW))
    else $error("pop from an empty queue changed the count");

endmodule

>>> test/double_ended_queue_tb.sv
`timescale 1ns / 100ps

module double_ended_queue_tb;
  import deq_pkg::*;

  localparam int CAPACITY = 16;
  localparam int RANDOM_PHASE_LEN = 14;

  typedef struct {
    status_t status;
    logic    has_value;
    word_t   value;
    logic    last;
  } listing_word_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [31:0] s_tdata = '0;
  logic [1:0]  s_tuser = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [31:0] m_tdata;
  logic [2:0]  m_tuser;
  logic        m_tlast;

  word_t         deque_contents[$];
  listing_word_t expected_listing[$];
  int            error_count = 0;
  bit            calm = 1'b0;
  int unsigned   stall_left = 0;
  int unsigned   stall_len;

  double_ended_queue #(.CAPACITY(CAPACITY)) i_dut (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .s_tuser(s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata),
    .m_tuser(m_tuser),
    .m_tlast(m_tlast)
  );

  always #6 clk = ~clk;

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (calm || r < 55) begin
      return 0;
    end else if (r < 92) begin
      return $urandom_range(1, 3);
    end else begin
      return $urandom_range(8, 30);
    end
  endfunction

  function automatic word_t pick_word();
    case ($urandom_range(0, 9))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return '1;
      3: return '0;
      default: return $urandom;
    endcase
  endfunction

  task automatic report_mismatch(string field, logic [31:0] got, logic [31:0] want);
    $display("mismatch at %0t on %s: got %h, expected %h", $time, field, got, want);
    error_count++;
  endtask

  task automatic predict_listing(cmd_t cmd, word_t value);
    status_t       st;
    listing_word_t w;
    int            n;
    st = ST_OK;
    case (cmd)
      CMD_PUSH_FRONT: begin
        if (deque_contents.size() >= CAPACITY) st = ST_OVERFLOW;
        else deque_contents.push_front(value);
      end
      CMD_PUSH_REAR: begin
        if (deque_contents.size() >= CAPACITY) st = ST_OVERFLOW;
        else deque_contents.push_back(value);
      end
      CMD_POP_FRONT: begin
        if (deque_contents.size() == 0) st = ST_UNDERFLOW;
        else void'(deque_contents.pop_front());
      end
      default: begin
        if (deque_contents.size() == 0) st = ST_UNDERFLOW;
        else void'(deque_contents.pop_back());
      end
    endcase
    n = deque_contents.size();
    if (n == 0) begin
      w = '{status: st, has_value: 1'b0, value: '0, last: 1'b1};
      expected_listing.push_back(w);
    end else begin
      for (int k = 0; k < n; k++) begin
        w = '{status: st, has_value: 1'b1, value: deque_contents[k], last: (k == n - 1)};
        expected_listing.push_back(w);
      end
    end
  endtask

  task automatic send_command(cmd_t cmd, word_t value);
    int unsigned gap;
    gap = pick_gap();
    if (gap != 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= value;
    s_tuser  <= cmd;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    predict_listing(cmd, value);
  endtask

  task automatic wait_for_listing_drain();
    s_tvalid <= 1'b0;
    while (expected_listing.size() != 0) @(posedge clk);
  endtask

  task automatic test_empty_pops();
    send_command(CMD_POP_FRONT, 32'h0000_0000);
    send_command(CMD_POP_REAR, 32'hffff_ffff);
  endtask

  task automatic test_extreme_words();
    send_command(CMD_PUSH_REAR, 32'h7fff_ffff);
    send_command(CMD_PUSH_FRONT, 32'h8000_0000);
    send_command(CMD_PUSH_REAR, 32'hffff_ffff);
    send_command(CMD_PUSH_FRONT, 32'h0000_0000);
    send_command(CMD_POP_FRONT, 32'h5555_5555);
    send_command(CMD_POP_REAR, 32'haaaa_aaaa);
    send_command(CMD_POP_FRONT, 32'h0000_0000);
    send_command(CMD_POP_REAR, 32'h0000_0000);
  endtask

  task automatic test_full_queue();
    for (int k = 0; k < CAPACITY; k++) begin
      send_command((k % 2 == 0) ? CMD_PUSH_FRONT : CMD_PUSH_REAR, 32'h1 << (2 * k + (k % 2)));
    end
    send_command(CMD_PUSH_FRONT, 32'hdead_beef);
    send_command(CMD_PUSH_REAR, 32'h1234_5678);
    send_command(CMD_POP_REAR, 32'h0000_0000);
  endtask

  task automatic test_random_traffic();
    int unsigned push_pct;
    cmd_t        cmd;
    for (int phase = 0; phase < 5; phase++) begin
      calm = (phase == 2);
      case (phase)
        0: push_pct = 70;
        1: push_pct = 25;
        2: push_pct = 50;
        3: push_pct = 85;
        default: push_pct = 15;
      endcase
      for (int k = 0; k < RANDOM_PHASE_LEN; k++) begin
        if ($urandom_range(0, 99) < push_pct) begin
          cmd = $urandom_range(0, 1) ? CMD_PUSH_REAR : CMD_PUSH_FRONT;
        end else begin
          cmd = $urandom_range(0, 1) ? CMD_POP_REAR : CMD_POP_FRONT;
        end
        send_command(cmd, pick_word());
      end
      if (phase == 1) wait_for_listing_drain();
    end
    calm = 1'b0;
  endtask

  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else if (calm) begin
      m_tready <= 1'b1;
      stall_left <= 0;
    end else if (stall_left != 0) begin
      m_tready <= 1'b0;
      stall_left <= stall_left - 1;
    end else begin
      stall_len = pick_gap();
      if (stall_len == 0) begin
        m_tready <= 1'b1;
      end else begin
        m_tready <= 1'b0;
        stall_left <= stall_len - 1;
      end
    end
  end

  always @(posedge clk) begin
    listing_word_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (expected_listing.size() == 0) begin
        report_mismatch("word with none expected", m_tdata, 32'h0);
      end else begin
        want = expected_listing.pop_front();
        if (m_tuser[1:0] !== want.status) begin
          report_mismatch("status", 32'(m_tuser[1:0]), 32'(want.status));
        end
        if (m_tuser[2] !== want.has_value) begin
          report_mismatch("has_value", 32'(m_tuser[2]), 32'(want.has_value));
        end
        if (m_tdata !== want.value) report_mismatch("value", m_tdata, want.value);
        if (m_tlast !== want.last) begin
          report_mismatch("last", 32'(m_tlast), 32'(want.last));
        end
      end
    end
  end

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_empty_pops();
    test_extreme_words();
    test_full_queue();
    wait_for_listing_drain();
    test_random_traffic();
    wait_for_listing_drain();
    repeat (40) @(posedge clk);
    if (expected_listing.size() != 0) begin
      report_mismatch("words left over", 32'(expected_listing.size()), 32'h0);
    end
    if (error_count == 0) begin
      $display("double_ended_queue test passed");
    end else begin
      $display("double_ended_queue test failed");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("double_ended_queue test failed");
    $finish;
  end

endmodule
